@@ rtl/core/swz_pkg.sv @@
// Package for the swizzled texel address generator.
// Holds payload and register types, register indexes and the swizzle tables.
// No dependencies.
package swz_pkg;

  localparam int unsigned CoordBits  = 11;
  localparam int unsigned AddrBits   = 22;
  localparam int unsigned WidthBits  = 6;
  localparam int unsigned OffsetBits = 13;  // byte offset inside an 8 KB page
  localparam int unsigned PageShift  = 13;
  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_BUFFER_WIDTH = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } swz_reg_e;

  typedef enum logic {
    FMT_8BPP = 1'b0,
    FMT_4BPP = 1'b1
  } swz_fmt_e;

  typedef struct packed {
    logic [CoordBits-1:0] coord_x;
    logic [CoordBits-1:0] coord_y;
  } swz_in_t;

  typedef struct packed {
    logic [AddrBits-1:0] byte_address;
    logic                high_nibble;
  } swz_out_t;

  // In-page result from the offset logic
  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic                  high_nibble;
  } swz_ofs_t;

  // Block swizzle, 8 bpp: [block row][block column]
  localparam logic [4:0] SWZ8_TBL [4][8] = '{
    '{5'd0,  5'd1,  5'd4,  5'd5,  5'd16, 5'd17, 5'd20, 5'd21},
    '{5'd2,  5'd3,  5'd6,  5'd7,  5'd18, 5'd19, 5'd22, 5'd23},
    '{5'd8,  5'd9,  5'd12, 5'd13, 5'd24, 5'd25, 5'd28, 5'd29},
    '{5'd10, 5'd11, 5'd14, 5'd15, 5'd26, 5'd27, 5'd30, 5'd31}
  };

  // Block swizzle, 4 bpp: [block row][block column]
  localparam logic [4:0] SWZ4_TBL [8][4] = '{
    '{5'd0,  5'd2,  5'd8,  5'd10},
    '{5'd1,  5'd3,  5'd9,  5'd11},
    '{5'd4,  5'd6,  5'd12, 5'd14},
    '{5'd5,  5'd7,  5'd13, 5'd15},
    '{5'd16, 5'd18, 5'd24, 5'd26},
    '{5'd17, 5'd19, 5'd25, 5'd27},
    '{5'd20, 5'd22, 5'd28, 5'd30},
    '{5'd21, 5'd23, 5'd29, 5'd31}
  };

  // Word within a column: [half swap][row parity][texel column]
  localparam logic [3:0] COLWORD_TBL [2][2][8] = '{
    '{'{4'd0, 4'd1, 4'd4, 4'd5, 4'd8, 4'd9, 4'd12, 4'd13},
      '{4'd2, 4'd3, 4'd6, 4'd7, 4'd10, 4'd11, 4'd14, 4'd15}},
    '{'{4'd8, 4'd9, 4'd12, 4'd13, 4'd0, 4'd1, 4'd4, 4'd5},
      '{4'd10, 4'd11, 4'd14, 4'd15, 4'd2, 4'd3, 4'd6, 4'd7}}
  };

endpackage

@@ rtl/core/swz_offset.sv @@
// Byte offset of a texel inside its 8 KB page, plus the nibble select.
// Pure combinational; uses swz_pkg tables.
module swz_offset import swz_pkg::*; (
  input  logic [CoordBits-1:0] coord_x_i,
  input  logic [CoordBits-1:0] coord_y_i,
  input  swz_fmt_e             fmt_i,
  output swz_ofs_t             ofs_o
);

  logic [1:0] col;
  logic [1:0] cy;
  logic       sub;
  logic [3:0] word;
  logic [4:0] blk;
  logic [1:0] byte_sel;

  assign col  = coord_y_i[3:2];
  assign cy   = coord_y_i[1:0];
  assign sub  = cy[1] ^ col[0];
  assign word = COLWORD_TBL[sub][cy[0]][coord_x_i[2:0]];

  always_comb begin
    case (fmt_i)
      FMT_8BPP: begin
        blk               = SWZ8_TBL[coord_y_i[5:4]][coord_x_i[6:4]];
        byte_sel          = {coord_x_i[3], cy[1]};
        ofs_o.high_nibble = 1'b0;
      end
      FMT_4BPP: begin
        // nibble index is {x[4:3], cy[1]}; the byte takes its upper two bits
        blk               = SWZ4_TBL[coord_y_i[6:4]][coord_x_i[6:5]];
        byte_sel          = coord_x_i[4:3];
        ofs_o.high_nibble = cy[1];
      end
      default: begin
        blk               = '0;
        byte_sel          = '0;
        ofs_o.high_nibble = 1'b0;
      end
    endcase
    ofs_o.offset = {blk, col, word, byte_sel};
  end

endmodule

@@ rtl/core/swizzled_texel_address.sv @@
// Top level of the swizzled texel address generator.
// Depends on swz_pkg and swz_offset.
//
// Usage: coordinates enter on the in channel (valid/ready, swz_in_t) and
// byte addresses leave on the out channel (valid/ready, swz_out_t), one
// result per item, in order. Registers are written on the cfg channel:
// index 0 base address, 1 buffer width (64-texel units), 2 pixel format;
// other indexes are dropped. cfg_ready_o is always high. Write registers
// only while no item is in flight.
//
// Two register stages: an input register and a result register, with the
// page/offset arithmetic (one 5x6 multiply, three adds) between them. Items
// pass from the input register to the result register, which drives
// out_valid_o, at one item per clock while the receiver is ready. On a stall
// each stage holds; ready falls only once both are full, so two can be held.
//
// Reset clears both stage valids and loads base 0, width 16, 8 bpp.
module swizzled_texel_address import swz_pkg::*; #(
  parameter int unsigned RAM_ADDR_BITS = 22
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  swz_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output swz_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [AddrBits-1:0]   cfg_data_i
);

  // Wrap mask: the narrower of the memory span and the output field
  localparam int unsigned MaskBits = (RAM_ADDR_BITS < AddrBits) ? RAM_ADDR_BITS : AddrBits;
  localparam logic [AddrBits-1:0] WrapMask = AddrBits'((64'd1 << MaskBits) - 64'd1);
  localparam int unsigned SumBits = AddrBits + 2;

  logic [AddrBits-1:0]  base_q;
  logic [WidthBits-1:0] width_q;
  swz_fmt_e             fmt_q;

  logic     s1_valid_q, s1_valid_d;
  swz_in_t  s1_data_q;
  logic     s2_valid_q, s2_valid_d;
  swz_out_t s2_data_q, s2_data_d;

  logic s1_ready;
  logic s2_ready;

  swz_ofs_t                ofs;
  logic [4:0]              page_row;
  logic [10:0]             row_prod;
  logic [10:0]             page;
  logic [SumBits-1:0]      addr_sum;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      width_q <= WidthBits'(16);
      fmt_q   <= FMT_8BPP;
    end else if (cfg_valid_i) begin
      case (swz_reg_e'(cfg_index_i))
        REG_BASE_ADDRESS: base_q  <= cfg_data_i;
        REG_BUFFER_WIDTH: width_q <= cfg_data_i[WidthBits-1:0];
        REG_PIXEL_FORMAT: fmt_q   <= swz_fmt_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Handshake: each stage takes a new item when empty or when it drains
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_data_q <= in_data_i;
    end
    if (s1_valid_q && s2_ready) begin
      s2_data_q <= s2_data_d;
    end
  end

  // Address arithmetic between the two stages
  swz_offset u_offset (
    .coord_x_i (s1_data_q.coord_x),
    .coord_y_i (s1_data_q.coord_y),
    .fmt_i     (fmt_q),
    .ofs_o     (ofs)
  );

  // Page row is y / page height; 4 bpp pages are twice as tall
  assign page_row = (fmt_q == FMT_4BPP) ? {1'b0, s1_data_q.coord_y[10:7]}
                                        : s1_data_q.coord_y[10:6];
  assign row_prod = {6'd0, page_row} * {5'd0, width_q};
  // (row * width * 64) / 128 truncates to (row * width) / 2
  assign page     = {7'd0, s1_data_q.coord_x[10:7]} + {1'b0, row_prod[10:1]};

  assign addr_sum = SumBits'(base_q) + (SumBits'(page) << PageShift)
                  + SumBits'(ofs.offset);

  assign s2_data_d.byte_address = addr_sum[AddrBits-1:0] & WrapMask;
  assign s2_data_d.high_nibble  = ofs.high_nibble;

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule
